[rtl/bdll_pkg.sv]
package bdll_pkg;

  localparam int CAPACITY = 64;
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_INSERT_AT  = 3'd2;
  localparam logic [2:0] CMD_FIND       = 3'd3;
  localparam logic [2:0] CMD_POP_BACK   = 3'd4;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd5;
  localparam logic [2:0] CMD_REMOVE     = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADPOS   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // One node: value and both links, held in a single memory word.
  typedef struct packed {
    logic [31:0]   value;
    logic [LW-1:0] nxt;
    logic [LW-1:0] prv;
  } node_t;

  localparam int NW = $bits(node_t);

endpackage

[rtl/bdll_ram.sv]
module bdll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/bounded_doubly_linked_list_top.sv]
// Bounded doubly linked list of up to CAPACITY signed 32-bit values. Raise start
// with a command while busy is low; busy rises in the next cycle and the single
// result appears on out_status, out_found_index and out_entry_count with
// out_valid high for one cycle, right after busy falls, which the receiver must
// take. Nodes live in one node memory with a registered read. A command that
// ends at once (full, bad position, empty, unused code) goes straight to its
// result. Find, remove by value and insert at an inner position walk the list
// from the head, one node at a time; push front/back and pops do not. After
// reset a clearing pass over all CAPACITY nodes chains the free list; busy
// stays high during it.
module bounded_doubly_linked_list_top
  import bdll_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_cmd,
  input  logic signed [31:0] in_item_value,
  input  logic [6:0]        in_position,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [5:0]        out_found_index,
  output logic [6:0]        out_entry_count
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;  // read issued, wait
  localparam logic [3:0] S_WALK  = 4'd3;  // data of cur_r available
  localparam logic [3:0] S_RDN   = 4'd4;  // neighbor read wait
  localparam logic [3:0] S_NBR   = 4'd5;  // neighbor data available
  localparam logic [3:0] S_RDF   = 4'd6;  // free node read wait
  localparam logic [3:0] S_FREE  = 4'd7;  // free node data available
  localparam logic [3:0] S_LINK  = 4'd8;  // neighbor link writes on insert; wait on remove
  localparam logic [3:0] S_NEW   = 4'd9;  // write the new node, or the successor link on remove
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic [LW-1:0] head_r, head_nxt, tail_r, tail_nxt, free_r, free_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [LW-1:0] cur_r, cur_nxt;     // node being visited
  logic [LW-1:0] idx_r, idx_nxt;     // index of cur_r (plus one on insert)
  logic [LW-1:0] pn_r, pn_nxt;       // insert: predecessor; remove: prev
  logic [LW-1:0] nx_r, nx_nxt;       // successor
  logic [LW-1:0] nn_r, nn_nxt;       // new node
  logic          hold_we_r, hold_we_nxt;
  logic [AW-1:0] hold_a_r, hold_a_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [5:0]    fi_r, fi_nxt;
  logic          ov_r, ov_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  node_t         wdata, rdata;

  bdll_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_nodes (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Control and sequencing.
  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; val_nxt = val_r; pos_nxt = pos_r;
    head_nxt = head_r; tail_nxt = tail_r; free_nxt = free_r; count_nxt = count_r;
    cur_nxt = cur_r; idx_nxt = idx_r; pn_nxt = pn_r; nx_nxt = nx_r; nn_nxt = nn_r;
    hold_we_nxt = hold_we_r; hold_a_nxt = hold_a_r;
    st_nxt = st_r; fi_nxt = fi_r; ov_nxt = 1'b0;
    we = 1'b0; waddr = cur_r[AW-1:0]; wdata = rdata; raddr = cur_r[AW-1:0];
    case (state_r)
      S_INIT: begin
        // Chain every node into the free list.
        we = 1'b1;
        wdata = '0;
        wdata.nxt = (cur_r == LW'(CAPACITY - 1)) ? NIL : cur_r + 1'b1;
        cur_nxt = cur_r + 1'b1;
        if (cur_r == LW'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd; val_nxt = in_item_value; pos_nxt = LW'(in_position);
          st_nxt = ST_OK; fi_nxt = '0; idx_nxt = '0; hold_we_nxt = 1'b0;
          state_nxt = S_DONE;
          case (in_cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
              if (count_r == LW'(CAPACITY)) begin
                st_nxt = ST_FULL;
              end else if (in_cmd == CMD_INSERT_AT && LW'(in_position) > count_r) begin
                st_nxt = ST_BADPOS;
              end else if (in_cmd == CMD_PUSH_BACK ||
                           (in_cmd == CMD_INSERT_AT && LW'(in_position) == count_r)) begin
                pn_nxt = tail_r; nx_nxt = NIL; state_nxt = S_RDF;
              end else if (in_cmd == CMD_PUSH_FRONT || in_position == 7'd0) begin
                pn_nxt = NIL; nx_nxt = head_r; state_nxt = S_RDF;
              end else begin
                // Walk to node pos-1; idx is the index of cur plus one.
                cur_nxt = head_r; idx_nxt = LW'(1); state_nxt = S_RD;
              end
            end
            CMD_FIND, CMD_REMOVE: begin
              if (count_r == '0) st_nxt = ST_NOTFOUND;
              else begin cur_nxt = head_r; state_nxt = S_RD; end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
              if (count_r == '0) st_nxt = ST_EMPTY;
              else begin
                cur_nxt = (in_cmd == CMD_POP_BACK) ? tail_r : head_r;
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: state_nxt = S_WALK;
      S_WALK: begin
        case (cmd_r)
          CMD_INSERT_AT: begin
            if (idx_r == pos_r) begin
              pn_nxt = cur_r; nx_nxt = rdata.nxt; state_nxt = S_RDF;
            end else begin
              cur_nxt = rdata.nxt; idx_nxt = idx_r + 1'b1; state_nxt = S_RD;
            end
          end
          CMD_FIND, CMD_REMOVE: begin
            if (rdata.value == val_r) begin
              if (cmd_r == CMD_FIND) begin
                fi_nxt = idx_r[5:0]; state_nxt = S_DONE;
              end else begin
                pn_nxt = rdata.prv; nx_nxt = rdata.nxt;
                state_nxt = S_RDN;
              end
            end else if (rdata.nxt == NIL || idx_r == LW'(CAPACITY - 1)) begin
              st_nxt = ST_NOTFOUND; state_nxt = S_DONE;
            end else begin
              cur_nxt = rdata.nxt; idx_nxt = idx_r + 1'b1; state_nxt = S_RD;
            end
          end
          default: begin
            pn_nxt = rdata.prv; nx_nxt = rdata.nxt; state_nxt = S_RDN;
          end
        endcase
        if (state_nxt == S_RDN) begin
          // Removal: return cur to the free list, then fix the neighbors.
          we = 1'b1; wdata = rdata; wdata.nxt = free_r;
          free_nxt = cur_r; count_nxt = count_r - 1'b1;
          if (rdata.prv == NIL) head_nxt = rdata.nxt;
          if (rdata.nxt == NIL) tail_nxt = rdata.prv;
          if (count_r == LW'(1)) begin head_nxt = NIL; tail_nxt = NIL; end
          raddr = (rdata.prv != NIL) ? rdata.prv[AW-1:0] : rdata.nxt[AW-1:0];
          hold_we_nxt = rdata.prv != NIL && rdata.nxt != NIL;
        end
      end
      S_RDN: begin
        // Keep the neighbor address so its data is ready in S_NBR.
        raddr = (pn_r != NIL) ? pn_r[AW-1:0] : nx_r[AW-1:0];
        if (pn_r == NIL && nx_r == NIL) state_nxt = S_DONE;
        else state_nxt = S_NBR;
      end
      S_NBR: begin
        we = 1'b1; wdata = rdata;
        if (pn_r != NIL) begin
          waddr = pn_r[AW-1:0]; wdata.nxt = nx_r;
        end else begin
          waddr = nx_r[AW-1:0]; wdata.prv = pn_r;
        end
        if (hold_we_r) begin
          // Both neighbors: read the successor next.
          raddr = nx_r[AW-1:0]; pn_nxt = NIL; hold_we_nxt = 1'b0;
          hold_a_nxt = pn_r[AW-1:0];
          state_nxt = S_LINK;
        end else state_nxt = S_DONE;
      end
      S_LINK: begin
        // Removal: hold the successor address so its data is ready in S_NEW.
        raddr = nx_r[AW-1:0];
        state_nxt = S_NEW;
      end
      S_NEW: begin
        if (cmd_r == CMD_PUSH_FRONT || cmd_r == CMD_PUSH_BACK ||
            cmd_r == CMD_INSERT_AT) begin
          // Write the new node itself.
          we = 1'b1; waddr = nn_r[AW-1:0];
          wdata.value = val_r; wdata.prv = pn_r; wdata.nxt = nx_r;
        end else begin
          we = 1'b1; waddr = nx_r[AW-1:0]; wdata = rdata;
          wdata.prv = {1'b0, hold_a_r};
        end
        state_nxt = S_DONE;
      end
      S_RDF: begin
        raddr = free_r[AW-1:0]; nn_nxt = free_r; state_nxt = S_FREE;
      end
      S_FREE: begin
        // Free node data arrives the cycle after its address was set.
        if (hold_we_r) begin
          free_nxt = rdata.nxt; count_nxt = count_r + 1'b1;
          if (pn_r == NIL) head_nxt = nn_r;
          if (nx_r == NIL) tail_nxt = nn_r;
          hold_we_nxt = 1'b0;
          if (pn_r != NIL) begin
            raddr = pn_r[AW-1:0]; hold_a_nxt = pn_r[AW-1:0]; state_nxt = S_LINK;
            cur_nxt = LW'(0);
          end else if (nx_r != NIL) begin
            raddr = nx_r[AW-1:0]; hold_a_nxt = nx_r[AW-1:0]; state_nxt = S_LINK;
            cur_nxt = LW'(1);
          end else state_nxt = S_NEW;
        end else begin
          raddr = free_r[AW-1:0]; hold_we_nxt = 1'b1;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Insert link fixes: S_LINK gets neighbor data and patches it.
    if (state_r == S_LINK && (cmd_r == CMD_PUSH_FRONT || cmd_r == CMD_PUSH_BACK ||
                              cmd_r == CMD_INSERT_AT)) begin
      we = 1'b1; waddr = hold_a_r; wdata = rdata;
      if (cur_r == LW'(0)) begin
        wdata.nxt = nn_r;
        if (nx_r != NIL) begin
          raddr = nx_r[AW-1:0]; hold_a_nxt = nx_r[AW-1:0];
          cur_nxt = LW'(1);
          state_nxt = S_LINK;
        end
      end else begin
        wdata.prv = nn_r;
      end
      if (!(cur_r == LW'(0) && nx_r != NIL)) state_nxt = S_NEW;
    end
  end

  // The successor read in S_LINK for insertion is issued in the previous cycle,
  // so its data is ready on entry to S_LINK.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; cur_r <= '0; head_r <= NIL; tail_r <= NIL;
      free_r <= '0; count_r <= '0; ov_r <= 1'b0; hold_we_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cur_r <= cur_nxt; head_r <= head_nxt;
      tail_r <= tail_nxt; free_r <= free_nxt; count_r <= count_nxt;
      ov_r <= ov_nxt; hold_we_r <= hold_we_nxt;
    end
    cmd_r <= cmd_nxt; val_r <= val_nxt; pos_r <= pos_nxt; idx_r <= idx_nxt;
    pn_r <= pn_nxt; nx_r <= nx_nxt; nn_r <= nn_nxt;
    hold_a_r <= hold_a_nxt; st_r <= st_nxt; fi_r <= fi_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_found_index = fi_r;
  assign out_entry_count = count_r;

  // The entry count never exceeds capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LW'(CAPACITY)) else $error("entry count above capacity");

  // A result strobe comes only while idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // An empty list has no head.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r == '0) |-> head_r == NIL)
    else $error("empty list with head");

endmodule

[tb/tb_bounded_doubly_linked_list_checker.sv]
`timescale 1ns / 1ps

// Watches the command and result channels of the list block, keeps its own
// model of the list contents and compares every result against it.
module tb_bounded_doubly_linked_list_checker
  import bdll_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_item_value,
  input  logic [6:0]         in_position,
  input  logic               out_valid,
  input  logic [2:0]         out_status,
  input  logic [5:0]         out_found_index,
  input  logic [6:0]         out_entry_count,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_index;
    logic [6:0] entry_count;
  } list_result_t;

  // The list is modeled as an ordered queue of values, front first.
  logic [31:0]  list_values[$];
  list_result_t expected_results[$];

  // Works out the result of one command and updates the modeled list.
  function automatic list_result_t apply_command(logic [2:0] cmd, logic [31:0] value,
                                                 logic [6:0] pos);
    list_result_t r;
    int idx;
    r = '0;
    idx = -1;
    if (cmd == CMD_FIND || cmd == CMD_REMOVE) begin
      foreach (list_values[i]) begin
        if (idx < 0 && list_values[i] == value) idx = i;
      end
    end
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
        if (list_values.size() >= CAPACITY) r.status = ST_FULL;
        else if (cmd == CMD_PUSH_FRONT) list_values.push_front(value);
        else if (cmd == CMD_PUSH_BACK) list_values.push_back(value);
        else if (pos > list_values.size()) r.status = ST_BADPOS;
        else list_values.insert(pos, value);
      end
      CMD_FIND: begin
        if (idx < 0) r.status = ST_NOTFOUND;
        else r.found_index = idx[5:0];
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (list_values.size() == 0) r.status = ST_EMPTY;
        else if (cmd == CMD_POP_BACK) void'(list_values.pop_back());
        else void'(list_values.pop_front());
      end
      CMD_REMOVE: begin
        if (idx < 0) r.status = ST_NOTFOUND;
        else list_values.delete(idx);
      end
      default: ;
    endcase
    r.entry_count = 7'(list_values.size());
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // Predict on each accepted command, compare on each result strobe.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      fail_count   <= 0;
      result_count <= 0;
      list_values.delete();
      expected_results.delete();
    end else begin
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d found=%0d count=%0d", $time,
                   out_status, out_found_index, out_entry_count);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.status !== out_status || want.found_index !== out_found_index ||
              want.entry_count !== out_entry_count) begin
            $display("%0t: mismatch expected status=%0d found=%0d count=%0d,",
                     $time, want.status, want.found_index, want.entry_count);
            $display("  actual status=%0d found=%0d count=%0d",
                     out_status, out_found_index, out_entry_count);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_command(in_cmd, in_item_value, in_position));
    end
  end

endmodule

[tb/tb_bounded_doubly_linked_list_top.sv]
`timescale 1ns / 1ps

// Drives commands into the list block and gives the verdict from the checker.
module tb_bounded_doubly_linked_list_top;
  import bdll_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_cmd;
  logic signed [31:0] in_item_value;
  logic [6:0]        in_position;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [5:0]        out_found_index;
  logic [6:0]        out_entry_count;
  int                fail_count;
  int                pending_count;
  int                result_count;
  longint            cycle_count = 0;
  int                sent_count;
  int                idle_pct;
  // Small pool so that finds and removes hit often.
  logic [31:0]       value_pool[8];

  bounded_doubly_linked_list_top dut (.*);

  tb_bounded_doubly_linked_list_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Issues one transaction, idling first at the current rate, and waits for it
  // to be taken. Start is dropped after the accepting edge.
  task automatic send_command(logic [2:0] cmd, logic [31:0] value, logic [6:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_cmd        <= cmd;
    in_item_value <= value;
    in_position   <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
    sent_count++;
  endtask

  // Picks a mostly well-formed command against the current list contents.
  task automatic send_random_command();
    int sel;
    logic [31:0] value;
    logic [6:0] pos;
    sel = $urandom_range(99);
    value = ($urandom_range(9) < 8) ? value_pool[$urandom_range(7)] : $urandom;
    pos = ($urandom_range(9) < 8) ? 7'($urandom_range(checker_i.list_values.size()))
                                   : 7'($urandom_range(127));
    if (sel < 14) send_command(CMD_PUSH_FRONT, value, 7'($urandom));
    else if (sel < 28) send_command(CMD_PUSH_BACK, value, 7'($urandom));
    else if (sel < 45) send_command(CMD_INSERT_AT, value, pos);
    else if (sel < 62) send_command(CMD_FIND, value, 7'($urandom));
    else if (sel < 72) send_command(CMD_POP_BACK, $urandom, 7'($urandom));
    else if (sel < 82) send_command(CMD_POP_FRONT, $urandom, 7'($urandom));
    else if (sel < 97) send_command(CMD_REMOVE, value, 7'($urandom));
    else send_command(CMD_UNUSED, $urandom, 7'($urandom));
  endtask

  initial begin
    longint wait_start;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_cmd        <= CMD_PUSH_FRONT;
    in_item_value <= '0;
    in_position   <= '0;
    idle_pct      = 0;
    sent_count    = 0;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list cases, extremes, every command, bad position.
    send_command(CMD_POP_BACK, 32'd0, 7'd0);
    send_command(CMD_POP_FRONT, 32'd0, 7'd0);
    send_command(CMD_FIND, 32'h8000_0000, 7'd0);
    send_command(CMD_REMOVE, 32'h7fff_ffff, 7'd0);
    send_command(CMD_INSERT_AT, 32'h1234, 7'd1);
    send_command(CMD_INSERT_AT, 32'h8000_0000, 7'd0);
    send_command(CMD_PUSH_BACK, 32'h7fff_ffff, 7'd0);
    send_command(CMD_PUSH_FRONT, 32'hffff_ffff, 7'h7f);
    send_command(CMD_INSERT_AT, 32'h0, 7'd3);
    send_command(CMD_INSERT_AT, 32'h5555_aaaa, 7'd2);
    send_command(CMD_INSERT_AT, 32'haaaa_5555, 7'd127);
    send_command(CMD_FIND, 32'h7fff_ffff, 7'd0);
    send_command(CMD_FIND, 32'h0, 7'd0);
    send_command(CMD_FIND, 32'h1, 7'd0);
    send_command(CMD_UNUSED, 32'hffff_ffff, 7'h7f);
    send_command(CMD_REMOVE, 32'h5555_aaaa, 7'd0);
    send_command(CMD_REMOVE, 32'h1, 7'd0);
    send_command(CMD_POP_FRONT, 32'd0, 7'd0);
    send_command(CMD_POP_BACK, 32'd0, 7'd0);

    // Fill to capacity, hit the full case on all inserts, find the deepest entry.
    while (checker_i.list_values.size() < CAPACITY)
      send_command(CMD_PUSH_BACK, $urandom, 7'($urandom));
    send_command(CMD_PUSH_FRONT, 32'd1, 7'd0);
    send_command(CMD_PUSH_BACK, 32'd1, 7'd0);
    send_command(CMD_INSERT_AT, 32'd1, 7'd0);
    send_command(CMD_FIND, checker_i.list_values[CAPACITY-1], 7'd0);
    send_command(CMD_REMOVE, checker_i.list_values[CAPACITY-1], 7'd0);

    // Random phases with different idle rates.
    idle_pct = 36;
    repeat (RANDOM_ITEMS / 3) send_random_command();
    idle_pct = 79;
    repeat (RANDOM_ITEMS / 3) send_random_command();
    idle_pct = 0;
    repeat (RANDOM_ITEMS / 3) send_random_command();

    wait_start = cycle_count;
    while (pending_count != 0 && cycle_count - wait_start < 10000) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d commands and checked %0d results across three idle patterns,",
             sent_count, result_count);
    $display("including empty, full, bad position and not-found cases.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
